// File: rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the damper start sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dss_pkg;

    localparam int NUM_DAMPERS      = 4;
    localparam int TICKS_PER_SECOND = 1000;
    localparam int ELAPSED_W        = 18;
    localparam int DELAY_W          = 8;
    localparam int CFG_IDX_W        = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_1     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_2     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_3     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_4     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 3'd4;

    typedef logic [NUM_DAMPERS-1:0] t_dmp_mask;
    typedef logic [ELAPSED_W-1:0]   t_elapsed;
    typedef logic signed [DELAY_W-1:0] t_delay;

    // per-damper decode of the delay registers, registered in dss_config
    typedef struct packed {
        t_dmp_mask                     enable;
        t_dmp_mask                     is_zero;
        t_dmp_mask                     is_pos;
        t_dmp_mask                     is_neg;
        logic [NUM_DAMPERS-1:0][ELAPSED_W-1:0] thr_first;
        logic [NUM_DAMPERS-1:0][ELAPSED_W-1:0] thr_second;
    } t_dly_info;

    // seconds (0..255 from dss_config) to ticks
    function automatic t_elapsed sec_to_ticks(input logic [DELAY_W:0] secs);
        return ELAPSED_W'(int'(secs) * TICKS_PER_SECOND);
    endfunction

endpackage

// File: rtl/dss_config.sv
// ----------------------------------------------------------------------------
// dss_config
// Configuration registers and registered per-damper tick thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dss_config (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dss_pkg::DELAY_W-1:0]   i_cfg_data,
    output dss_pkg::t_dly_info            o_info
);
    import dss_pkg::*;

    t_delay    r_delay [NUM_DAMPERS];
    t_dmp_mask r_enable;
    t_dly_info r_info;
    t_dly_info n_info;
    t_delay    min_dly;
    logic [DELAY_W:0] dsx;
    logic [DELAY_W:0] msx;
    logic [DELAY_W:0] mag;
    logic [DELAY_W:0] diff;

    assign o_cfg_ready = 1'b1;
    assign o_info      = r_info;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DAMPERS; i++) begin
                r_delay[i] <= '0;
            end
            r_enable <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_DELAY_1:     r_delay[0] <= i_cfg_data;
                REG_DELAY_2:     r_delay[1] <= i_cfg_data;
                REG_DELAY_3:     r_delay[2] <= i_cfg_data;
                REG_DELAY_4:     r_delay[3] <= i_cfg_data;
                REG_ENABLE_MASK: r_enable   <= i_cfg_data[NUM_DAMPERS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        min_dly = r_delay[0];
        for (int i = 1; i < NUM_DAMPERS; i++) begin
            if (r_delay[i] < min_dly) begin
                min_dly = r_delay[i];
            end
        end
        msx    = {min_dly[DELAY_W-1], min_dly};
        n_info = '0;
        n_info.enable = r_enable;
        dsx  = '0;
        mag  = '0;
        diff = '0;
        for (int i = 0; i < NUM_DAMPERS; i++) begin
            dsx  = {r_delay[i][DELAY_W-1], r_delay[i]};
            mag  = dsx[DELAY_W] ? ((DELAY_W+1)'(0) - dsx) : dsx;
            // offset from the earliest damper, never negative
            diff = dsx - msx;
            n_info.is_zero[i]    = (r_delay[i] == '0);
            n_info.is_pos[i]     = !dsx[DELAY_W] && (r_delay[i] != '0);
            n_info.is_neg[i]     = dsx[DELAY_W];
            n_info.thr_first[i]  = sec_to_ticks(diff);
            n_info.thr_second[i] = sec_to_ticks(mag);
        end
    end

    always_ff @(posedge i_clk) begin
        r_info <= n_info;
    end

endmodule

// File: rtl/damper_start_sequencer.sv
// ----------------------------------------------------------------------------
// damper_start_sequencer
// Sequences four ventilation dampers around fan start, one tick per transaction.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  tick in | in        | i_in_valid / o_in_stall    | i_unit_run, i_fans_allow
//  result  | out       | o_out_valid / i_out_stall  | o_damper_open_mask,
//          |           |                            | o_fan_permit_mask, o_all_permit
//  config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  One tick per cycle sustained while the result is not stalled; a tick passes
//  the input register, then the state update into the state/result registers.
//  Thresholds are registered from the configuration registers every cycle.
//  Synchronous reset clears configuration, sequencing state and both stages.
//  A stalled result holds; input stalls only when both stages are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module damper_start_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_unit_run,
    input  logic                            i_fans_allow,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [dss_pkg::NUM_DAMPERS-1:0] o_damper_open_mask,
    output logic [dss_pkg::NUM_DAMPERS-1:0] o_fan_permit_mask,
    output logic                            o_all_permit,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dss_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dss_pkg::DELAY_W-1:0]     i_cfg_data
);
    import dss_pkg::*;

    t_dly_info info;

    logic      r_in_valid;
    logic      r_unit_run;
    logic      r_fans_allow;
    logic      r_out_valid;
    logic      adv;

    t_elapsed  r_elapsed;
    t_dmp_mask r_first;
    t_dmp_mask r_second;
    t_dmp_mask r_permit;
    t_dmp_mask r_open;

    t_elapsed  n_elapsed;
    t_dmp_mask n_first;
    t_dmp_mask n_second;
    t_dmp_mask n_permit;
    t_dmp_mask n_open;

    dss_config u_config (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_info      (info)
    );

    assign adv         = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !adv;
    assign o_out_valid = r_out_valid;

    assign o_damper_open_mask = r_open;
    assign o_fan_permit_mask  = r_permit;
    assign o_all_permit       = &r_permit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_unit_run   <= i_unit_run;
            r_fans_allow <= i_fans_allow;
        end
    end

    always_comb begin
        n_elapsed = r_elapsed;
        n_first   = r_first;
        n_second  = r_second;
        n_permit  = r_permit;
        n_open    = r_open;
        if (!r_unit_run) begin
            n_elapsed = '0;
            n_first   = '1;
            n_second  = '1;
            n_permit  = '0;
            n_open    = '0;
        end else begin
            if (r_elapsed != '1) begin
                n_elapsed = r_elapsed + t_elapsed'(1);
            end
            for (int i = 0; i < NUM_DAMPERS; i++) begin
                if (info.enable[i] && r_first[i]) begin
                    if (info.is_zero[i] && (n_elapsed > info.thr_first[i])) begin
                        n_permit[i] = 1'b1;
                        n_open[i]   = 1'b1;
                        n_first[i]  = 1'b0;
                    end else if (info.is_pos[i]) begin
                        n_permit[i] = 1'b1;
                        n_first[i]  = 1'b0;
                    end else if (info.is_neg[i] && (n_elapsed > info.thr_first[i])) begin
                        n_open[i]   = 1'b1;
                        n_first[i]  = 1'b0;
                    end
                end
                if (r_second[i]) begin
                    if (info.is_pos[i] && r_fans_allow
                        && (n_elapsed > info.thr_second[i])) begin
                        n_open[i]   = 1'b1;
                        n_second[i] = 1'b0;
                    end else if (info.is_neg[i] && (n_elapsed > info.thr_second[i])) begin
                        n_permit[i] = 1'b1;
                        n_second[i] = 1'b0;
                    end
                end
                // disabled damper permits at once
                if (!info.enable[i] && r_first[i]) begin
                    n_permit[i] = 1'b1;
                    n_first[i]  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_elapsed   <= '0;
            r_first     <= '1;
            r_second    <= '1;
            r_permit    <= '0;
            r_open      <= '0;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
                r_elapsed   <= n_elapsed;
                r_first     <= n_first;
                r_second    <= n_second;
                r_permit    <= n_permit;
                r_open      <= n_open;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_unit_run) |=> (r_permit == '0 && r_open == '0 && r_elapsed == '0))
        else $error("stop tick did not clear damper state");

    a_elapsed_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_unit_run && r_elapsed != '1)
        |=> (r_elapsed == $past(r_elapsed) + t_elapsed'(1)))
        else $error("elapsed counter did not advance by one tick");

    a_permit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_unit_run) |=> ((r_permit & $past(r_permit)) == $past(r_permit)))
        else $error("fan permit dropped while unit running");

    a_open_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_unit_run) |=> ((r_open & $past(r_open)) == $past(r_open)))
        else $error("damper closed while unit running");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free stage");

endmodule
